// ===== hdl/pwb_pkg.sv =====
// Shared types, constants and the divide-by-255 helper of the pixel wash blend unit.
`timescale 1ns / 1ps

package pwb_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_LERP   = 2'd2,
		MODE_NONE   = 2'd3
	} blend_mode_t;

	// Register indexes on the configuration port.
	localparam logic REG_BLEND_MODE = 1'b0;
	localparam logic REG_WASH_COLOR = 1'b1;

	localparam logic [31:0] WASH_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK_RB    = 32'h00FF_00FF;
	localparam logic [31:0] MASK_G     = 32'h0000_FF00;
	localparam logic [7:0]  CH_MAX     = 8'd255;
	localparam logic [15:0] ROUND_255  = 16'd127;

	typedef struct packed {
		logic [31:0] dest_pixel;
		logic [31:0] src_pixel;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        write_enable;
	} out_word_t;

	typedef struct packed {
		blend_mode_t blend_mode;
		logic [31:0] wash_color;
	} cfg_t;

	// Exact x / 255 for x below 65280 by reciprocal with correction.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ===== hdl/pwb_cfg.sv =====
// Configuration register file of the pixel wash blend unit on an APB-style port.
`timescale 1ns / 1ps

module pwb_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output pwb_pkg::cfg_t cfg
);

	pwb_pkg::blend_mode_t mode_q;
	logic [31:0]          wash_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pwb_pkg::MODE_NORMAL;
			wash_q <= pwb_pkg::WASH_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				pwb_pkg::REG_BLEND_MODE: mode_q <= pwb_pkg::blend_mode_t'(pwdata[1:0]);
				pwb_pkg::REG_WASH_COLOR: wash_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pwb_pkg::REG_BLEND_MODE: prdata = {30'd0, mode_q};
			pwb_pkg::REG_WASH_COLOR: prdata = wash_q;
			default:                 prdata = '0;
		endcase
	end

	assign cfg.blend_mode = mode_q;
	assign cfg.wash_color = wash_q;

endmodule

// ===== hdl/pixel_wash_blend_unit.sv =====
// Top level of the pixel wash blend unit: four-stage blend pipeline.
//
// Usage: drive a source and destination pixel word on pixels and pulse start.
// busy is always low, so a word is taken on every cycle that start is high;
// one pixel per cycle is sustained with no bubbles.
// Each word yields exactly one result word: done is high for one cycle with
// result.write_enable and result.out_pixel. A skipped pixel carries
// write_enable low and out_pixel zero.
// Each result passes through the four register stages: colour products, the divide
// by 255, the lerp and wash multiplies, and the final adds and selection.
// The receiver cannot stall, so no result is ever held or dropped.
// blend_mode and wash_color are written through the APB-style port; the user
// must do so only while no word is in flight, which the block does not enforce.
// pready is always high. Reset clears the pipeline valid bits and sets
// blend_mode to normal and wash_color to all ones.
`timescale 1ns / 1ps

module pixel_wash_blend_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  pwb_pkg::in_word_t pixels,
	output logic              done,
	output pwb_pkg::out_word_t result
);

	pwb_pkg::cfg_t cfg;

	pwb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: rounded colour products.
	logic                 v_s1, wall_s1;
	pwb_pkg::blend_mode_t mode_s1;
	logic [31:0]          src_s1, dst_s1;
	logic [15:0]          pa_s1, pr_s1, pg_s1, pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= cfg.blend_mode;
		wall_s1 <= (cfg.wash_color == pwb_pkg::WASH_RESET);
		src_s1  <= pixels.src_pixel;
		dst_s1  <= pixels.dest_pixel;
		pa_s1   <= cfg.wash_color[31:24] * pixels.src_pixel[31:24] + pwb_pkg::ROUND_255;
		pr_s1   <= cfg.wash_color[7:0]   * pixels.src_pixel[7:0]   + pwb_pkg::ROUND_255;
		pg_s1   <= cfg.wash_color[15:8]  * pixels.src_pixel[15:8]  + pwb_pkg::ROUND_255;
		pb_s1   <= cfg.wash_color[23:16] * pixels.src_pixel[23:16] + pwb_pkg::ROUND_255;
	end

	// Stage 2: divide by 255 to get the washed channels.
	logic                 v_s2, wall_s2;
	pwb_pkg::blend_mode_t mode_s2;
	logic [31:0]          src_s2, dst_s2;
	logic [7:0]           wa_s2, r_s2, g_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		wall_s2 <= wall_s1;
		src_s2  <= src_s1;
		dst_s2  <= dst_s1;
		wa_s2   <= pwb_pkg::div255(pa_s1);
		r_s2    <= pwb_pkg::div255(pr_s1);
		g_s2    <= pwb_pkg::div255(pg_s1);
		b_s2    <= pwb_pkg::div255(pb_s1);
	end

	// Stage 3: lerp products and additive products.
	logic [7:0]  lerp_w;
	logic [31:0] tgt_rb, tgt_g, diff_rb, diff_g;
	logic [39:0] full_rb, full_g;

	always_comb begin
		if (mode_s2 == pwb_pkg::MODE_NORMAL) begin
			lerp_w = src_s2[31:24];
			tgt_rb = src_s2 & pwb_pkg::MASK_RB;
			tgt_g  = src_s2 & pwb_pkg::MASK_G;
		end else begin
			lerp_w = wa_s2;
			tgt_rb = {8'd0, b_s2, 8'd0, r_s2};
			tgt_g  = {16'd0, g_s2, 8'd0};
		end
		diff_rb = tgt_rb - (dst_s2 & pwb_pkg::MASK_RB);
		diff_g  = tgt_g - (dst_s2 & pwb_pkg::MASK_G);
		full_rb = {32'd0, lerp_w} * {8'd0, diff_rb};
		full_g  = {32'd0, lerp_w} * {8'd0, diff_g};
	end

	logic                 v_s3, wall_s3;
	pwb_pkg::blend_mode_t mode_s3;
	logic [31:0]          src_s3, dst_s3, lrb_s3, lg_s3;
	logic [7:0]           wa_s3, r_s3, g_s3, b_s3;
	logic [15:0]          ar_s3, ag_s3, ab_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		wall_s3 <= wall_s2;
		src_s3  <= src_s2;
		dst_s3  <= dst_s2;
		lrb_s3  <= full_rb[31:0];
		lg_s3   <= full_g[31:0];
		wa_s3   <= wa_s2;
		r_s3    <= r_s2;
		g_s3    <= g_s2;
		b_s3    <= b_s2;
		ar_s3   <= r_s2 * wa_s2;
		ag_s3   <= g_s2 * wa_s2;
		ab_s3   <= b_s2 * wa_s2;
	end

	// Stage 4: final adds, saturation and selection.
	logic [31:0] lerp_px, add_px;
	logic [8:0]  sum_r;
	logic [16:0] sum_g;
	logic [24:0] sum_b;
	logic [7:0]  byte_r, byte_g, byte_b;
	pwb_pkg::out_word_t   res_next;

	always_comb begin
		lerp_px = (((dst_s3 & pwb_pkg::MASK_RB) + (lrb_s3 >> 8)) & pwb_pkg::MASK_RB)
		        | (((dst_s3 & pwb_pkg::MASK_G) + (lg_s3 >> 8)) & pwb_pkg::MASK_G);
		// The low bits of the green and blue products take part in the saturation compare; red uses only the high byte.
		sum_r  = {1'b0, dst_s3[7:0]} + {1'b0, ar_s3[15:8]};
		sum_g  = {1'b0, dst_s3[15:8], 8'd0} + {1'b0, ag_s3};
		sum_b  = {1'b0, dst_s3[23:16], 16'd0} + {1'b0, ab_s3, 8'd0};
		byte_r = (sum_r > 9'h0FF)       ? pwb_pkg::CH_MAX : sum_r[7:0];
		byte_g = (sum_g > 17'h0FF00)    ? pwb_pkg::CH_MAX : sum_g[15:8];
		byte_b = (sum_b > 25'h0FF0000)  ? pwb_pkg::CH_MAX : sum_b[23:16];
		add_px = {8'd0, byte_b, byte_g, byte_r};
	end

	always_comb begin
		res_next = '0;
		if (src_s3[31:24] != 8'd0) begin
			unique case (mode_s3)
				pwb_pkg::MODE_NORMAL: begin
					res_next.write_enable = 1'b1;
					res_next.out_pixel    = (src_s3[31:24] == pwb_pkg::CH_MAX) ? src_s3
					                                                          : lerp_px;
				end
				pwb_pkg::MODE_ADD: begin
					if (wa_s3 != 8'd0 && (r_s3 != 8'd0 || g_s3 != 8'd0 || b_s3 != 8'd0)) begin
						res_next.write_enable = 1'b1;
						res_next.out_pixel    = add_px;
					end
				end
				pwb_pkg::MODE_LERP: begin
					if (wa_s3 != 8'd0) begin
						res_next.write_enable = 1'b1;
						priority if (wa_s3 == pwb_pkg::CH_MAX && wall_s3)
							res_next.out_pixel = src_s3;
						else if (wa_s3 == pwb_pkg::CH_MAX)
							res_next.out_pixel = {8'd0, b_s3, g_s3, r_s3};
						else
							res_next.out_pixel = lerp_px;
					end
				end
				pwb_pkg::MODE_NONE: ;
				default: ;
			endcase
		end
	end

	logic                 v_s4;
	pwb_pkg::blend_mode_t mode_s4;
	pwb_pkg::out_word_t   res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		res_s4  <= res_next;
	end

	assign done   = v_s4;
	assign result = res_s4;

	// Every accepted word comes out as a done strobe after the four register stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted word did not produce a result after four cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without a matching accepted word");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.write_enable |-> result.out_pixel == 32'd0)
		else $error("skipped pixel carries a nonzero value");

	a_mode_none: assert property (@(posedge clk) disable iff (!arst_n)
		done && mode_s4 == pwb_pkg::MODE_NONE |-> !result.write_enable)
		else $error("write enabled in the never-write mode");

endmodule

// ===== sim/pixel_wash_blend_unit_test.sv =====
// Self-checking regression of the pixel wash blend unit with its own blend predictor.
`timescale 1ns / 1ps

module pixel_wash_blend_unit_test;

	localparam logic [31:0] MASK_R = 32'h0000_00FF;
	localparam logic [31:0] MASK_B = 32'h00FF_0000;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	pwb_pkg::in_word_t pixels = '0;
	logic done;
	pwb_pkg::out_word_t result;

	pixel_wash_blend_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.pixels(pixels),
		.done(done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Register copies that the predictor works from.
	pwb_pkg::blend_mode_t cfg_mode = pwb_pkg::MODE_NORMAL;
	logic [31:0] cfg_wash = pwb_pkg::WASH_RESET;

	pwb_pkg::in_word_t pending_pixels[$];
	pwb_pkg::out_word_t expected_results[$];

	int n_mismatch = 0;
	int n_accepted = 0;
	int n_written = 0;
	int n_skipped = 0;
	int n_settings = 0;
	int n_readbacks = 0;
	int n_drains = 0;
	int idle_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	bit drain_hold = 0;
	bit steady_feed = 0;

	function automatic logic [31:0] mul_255(input logic [7:0] a, input logic [7:0] b);
		logic [31:0] p;
		p = {24'd0, a} * {24'd0, b} + 32'd127;
		return p / 32'd255;
	endfunction

	// Both channel groups wrap in 32 bits before masking.
	function automatic logic [31:0] lerp_pixel(input logic [31:0] d, input logic [31:0] rb,
			input logic [31:0] g, input logic [31:0] w);
		logic [31:0] drb, dg, t, brb, bg;
		drb = d & pwb_pkg::MASK_RB;
		dg = d & pwb_pkg::MASK_G;
		t = w * (rb - drb);
		brb = drb + (t >> 8);
		t = w * (g - dg);
		bg = dg + (t >> 8);
		return (brb & pwb_pkg::MASK_RB) | (bg & pwb_pkg::MASK_G);
	endfunction

	function automatic logic [31:0] sat_channel(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] lim);
		logic [31:0] s;
		s = a + b;
		return ((s > lim) ? lim : s) & lim;
	endfunction

	function automatic pwb_pkg::out_word_t blended_pixel(input pwb_pkg::in_word_t w,
			input pwb_pkg::blend_mode_t mode, input logic [31:0] wash);
		logic [31:0] src, dst, wa, r, g, b, ar, ag, ab, px;
		logic we;
		pwb_pkg::out_word_t res;
		src = w.src_pixel;
		dst = w.dest_pixel;
		we = 1'b0;
		px = '0;
		if (src[31:24] != 8'd0) begin
			if (mode == pwb_pkg::MODE_NORMAL) begin
				we = 1'b1;
				if (src[31:24] == pwb_pkg::CH_MAX)
					px = src;
				else
					px = lerp_pixel(dst, src & pwb_pkg::MASK_RB, src & pwb_pkg::MASK_G,
						{24'd0, src[31:24]});
			end else if (mode == pwb_pkg::MODE_ADD || mode == pwb_pkg::MODE_LERP) begin
				wa = mul_255(wash[31:24], src[31:24]);
				r = mul_255(wash[7:0], src[7:0]);
				g = mul_255(wash[15:8], src[15:8]);
				b = mul_255(wash[23:16], src[23:16]);
				if (wa != 0) begin
					if (mode == pwb_pkg::MODE_ADD) begin
						if ((r | g | b) != 0) begin
							ar = (r * wa) >> 8;
							ag = ((g << 8) * wa) >> 8;
							ab = ((b << 16) * wa) >> 8;
							we = 1'b1;
							px = sat_channel(dst & MASK_B, ab, MASK_B)
								| sat_channel(dst & pwb_pkg::MASK_G, ag, pwb_pkg::MASK_G)
								| sat_channel(dst & MASK_R, ar, MASK_R);
						end
					end else begin
						we = 1'b1;
						if (wa == {24'd0, pwb_pkg::CH_MAX})
							px = (wash == pwb_pkg::WASH_RESET) ? src
								: (r | (g << 8) | (b << 16));
						else
							px = lerp_pixel(dst, r | (b << 16), g << 8, wa);
					end
				end
			end
		end
		res.write_enable = we;
		res.out_pixel = we ? px : '0;
		return res;
	endfunction

	function automatic pwb_pkg::in_word_t pixel_pair(input logic [31:0] src,
			input logic [31:0] dest);
		pwb_pkg::in_word_t w;
		w.src_pixel = src;
		w.dest_pixel = dest;
		return w;
	endfunction

	function automatic logic [31:0] rand_wash();
		logic [31:0] c;
		c = $urandom();
		case ($urandom_range(0, 3))
			0: c[31:24] = pwb_pkg::CH_MAX;
			1: c[31:24] = 8'($urandom_range(1, 3));
			default: ;
		endcase
		return c;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("MISMATCH %s: expected %08h, got %08h", what, want, got);
	endtask

	task automatic reg_access(input logic idx, input logic wr, input logic [31:0] val,
			output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			if (idx == pwb_pkg::REG_BLEND_MODE)
				cfg_mode = pwb_pkg::blend_mode_t'(val[1:0]);
			else
				cfg_wash = val;
		end
	endtask

	task automatic set_config(input pwb_pkg::blend_mode_t mode, input logic [31:0] wash);
		logic [31:0] rd;
		reg_access(pwb_pkg::REG_BLEND_MODE, 1'b1, {30'd0, mode}, rd);
		reg_access(pwb_pkg::REG_WASH_COLOR, 1'b1, wash, rd);
		reg_access(pwb_pkg::REG_BLEND_MODE, 1'b0, '0, rd);
		if (rd[1:0] !== cfg_mode)
			note_mismatch("blend_mode readback", {30'd0, cfg_mode}, rd);
		reg_access(pwb_pkg::REG_WASH_COLOR, 1'b0, '0, rd);
		if (rd !== cfg_wash)
			note_mismatch("wash_color readback", cfg_wash, rd);
		n_readbacks += 2;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_pixels.size() != 0 || start || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int idx, input pwb_pkg::blend_mode_t mode,
			input logic [31:0] wash, input bit write_regs, input bit steady,
			input int n_random);
		logic [31:0] s, d;
		if (write_regs)
			set_config(mode, wash);
		steady_feed = steady;
		n_settings++;
		case (idx)
			0: begin
				pending_pixels.push_back(pixel_pair(32'h00FF_FFFF, 32'h1234_5678));
				pending_pixels.push_back(pixel_pair(32'hFFA1_B2C3, 32'h0000_0000));
				pending_pixels.push_back(pixel_pair(32'h01FF_FFFF, 32'h0000_0000));
				pending_pixels.push_back(pixel_pair(32'h80FF_FFFF, 32'hFFFF_FFFF));
				pending_pixels.push_back(pixel_pair(32'hFE00_0000, 32'hFFFF_FFFF));
				pending_pixels.push_back(pixel_pair(32'h7F12_3456, 32'h89AB_CDEF));
			end
			1: begin
				pending_pixels.push_back(pixel_pair(32'h00FF_FFFF, 32'h0102_0304));
				pending_pixels.push_back(pixel_pair(32'h8000_0000, 32'h5555_5555));
				pending_pixels.push_back(pixel_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
				pending_pixels.push_back(pixel_pair(32'hFF01_0203, 32'h0000_0000));
				pending_pixels.push_back(pixel_pair(32'h4080_8080, 32'h8080_8080));
			end
			// The washed alpha rounds to zero here.
			2: pending_pixels.push_back(pixel_pair(32'h7FFF_FFFF, 32'hA5A5_A5A5));
			3: begin
				pending_pixels.push_back(pixel_pair(32'hFF12_3456, 32'h0BAD_F00D));
				pending_pixels.push_back(pixel_pair(32'h0012_3456, 32'h0BAD_F00D));
				pending_pixels.push_back(pixel_pair(32'h80FF_00FF, 32'hFF00_FF00));
			end
			4: begin
				pending_pixels.push_back(pixel_pair(32'hFFFF_FFFF, 32'h1357_9BDF));
				pending_pixels.push_back(pixel_pair(32'hFF00_0000, 32'hFFFF_FFFF));
			end
			5: pending_pixels.push_back(pixel_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
			6: pending_pixels.push_back(pixel_pair(32'hFFFF_FFFF, 32'h0000_0000));
			default: ;
		endcase
		repeat (n_random) begin
			s = $urandom();
			d = $urandom();
			// Bias the source toward the alpha and colour values that pick a path.
			case ($urandom_range(0, 9))
				0: s[31:24] = 8'd0;
				1, 2: s[31:24] = pwb_pkg::CH_MAX;
				3: s[31:24] = 8'($urandom_range(1, 2));
				4: s[23:0] = '0;
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0: d = '0;
				1: d = '1;
				default: ;
			endcase
			pending_pixels.push_back(pixel_pair(s, d));
		end
		wait_idle();
	endtask

	// Driver: offers queued words in bursts, and now and then holds until the pipeline drains.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_results.push_back(blended_pixel(pixels, cfg_mode, cfg_wash));
			void'(pending_pixels.pop_front());
			n_accepted++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = steady_feed ? 0 : $urandom_range(0, 5);
				if (!steady_feed && (n_drains == 0 || $urandom_range(0, 11) == 0)) begin
					drain_hold = 1;
					n_drains++;
				end
			end
		end else if (gap_left > 0) begin
			gap_left--;
		end
		if (drain_hold && expected_results.size() == 0)
			drain_hold = 0;
		if (!drain_hold && gap_left == 0 && pending_pixels.size() != 0) begin
			start <= 1'b1;
			pixels <= pending_pixels[0];
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: every strobed result is matched against the oldest prediction.
	always @(posedge clk) begin
		pwb_pkg::out_word_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				note_mismatch("result with none expected", '0, result.out_pixel);
			end else begin
				want = expected_results.pop_front();
				if (result.write_enable !== want.write_enable)
					note_mismatch("write_enable", {31'd0, want.write_enable},
						{31'd0, result.write_enable});
				if (result.out_pixel !== want.out_pixel)
					note_mismatch("out_pixel", want.out_pixel, result.out_pixel);
				if (result.write_enable)
					n_written++;
				else
					n_skipped++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("pixel_wash_blend_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(0, pwb_pkg::MODE_NORMAL, pwb_pkg::WASH_RESET, 1'b0, 1'b0, 150);
		run_phase(1, pwb_pkg::MODE_ADD, pwb_pkg::WASH_RESET, 1'b1, 1'b0, 150);
		run_phase(2, pwb_pkg::MODE_ADD, 32'h01FF_FFFF, 1'b1, 1'b0, 120);
		run_phase(3, pwb_pkg::MODE_LERP, pwb_pkg::WASH_RESET, 1'b1, 1'b1, 150);
		run_phase(4, pwb_pkg::MODE_LERP, 32'hFF80_4020, 1'b1, 1'b0, 150);
		run_phase(5, pwb_pkg::MODE_LERP, 32'h0000_0000, 1'b1, 1'b0, 100);
		run_phase(6, pwb_pkg::MODE_NONE, rand_wash(), 1'b1, 1'b0, 100);
		run_phase(7, pwb_pkg::MODE_ADD, rand_wash(), 1'b1, 1'b0, 150);
		run_phase(8, pwb_pkg::MODE_NORMAL, 32'h0000_0000, 1'b1, 1'b1, 150);
		run_phase(9, pwb_pkg::MODE_LERP, rand_wash(), 1'b1, 1'b0, 150);
		run_phase(10, pwb_pkg::MODE_ADD, 32'hFFFF_FF00, 1'b1, 1'b0, 100);
		if (expected_results.size() != 0) begin
			$display("%0d predicted results never arrived", expected_results.size());
			n_mismatch += expected_results.size();
		end
		$display("Covered %0d pixels in %0d register settings across all blend modes.",
			n_accepted, n_settings);
		$display("%0d results written, %0d skipped, %0d register readbacks, %0d drain pauses.",
			n_written, n_skipped, n_readbacks, n_drains);
		if (n_mismatch == 0) begin
			$display("pixel_wash_blend_unit regression: pass");
		end else begin
			$display("%0d mismatches", n_mismatch);
			$display("pixel_wash_blend_unit regression: fail");
		end
		$finish;
	end

endmodule
